// File: hw/rtl/epvd_pkg.sv
// shared types, constants and microcode layout for the encoder pid velocity drive
`timescale 1ns / 1ps
`default_nettype none
package epvd_pkg;

  // pwm scaling
  localparam int PWM_FULL_SCALE     = 1023;
  localparam int COMMAND_FULL_SCALE = 1000;

  // field widths
  localparam int GAIN_W   = 16;
  localparam int DESIRE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int SPEED_W  = 15;
  localparam int ERR_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int SUM_W    = 24;
  localparam int CMD_W    = 16;
  localparam int DUTY_W   = 10;
  localparam int MULB_W   = SUM_W + 1;
  localparam int PROD_W   = GAIN_W + MULB_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int QT_W     = ACC_W - 8;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  // duty = pwm_full_scale * mag / command_full_scale through a reciprocal multiply
  localparam int MAG_W      = $clog2(COMMAND_FULL_SCALE + 1);
  localparam int PWM_W      = $clog2(PWM_FULL_SCALE + 1);
  localparam int DPROD_W    = MAG_W + PWM_W;
  localparam int DIV_SHIFT  = DPROD_W + MAG_W;
  localparam int DIV_MULT_W = DIV_SHIFT - MAG_W + 2;
  localparam int DFULL_W    = DPROD_W + DIV_MULT_W;
  localparam int DUTY_Q_W   = (PWM_W > DUTY_W) ? PWM_W : DUTY_W;
  localparam longint DIV_MULT_L =
    ((longint'(1) << DIV_SHIFT) + COMMAND_FULL_SCALE - 1) / COMMAND_FULL_SCALE;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(DIV_MULT_L);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  // microcode store
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] UA_DISPATCH  = 4'd0;
  localparam logic [PC_W-1:0] UA_LATCH     = 4'd1;
  localparam logic [PC_W-1:0] UA_MUL_P     = 4'd2;
  localparam logic [PC_W-1:0] UA_MUL_I     = 4'd3;
  localparam logic [PC_W-1:0] UA_MUL_D     = 4'd4;
  localparam logic [PC_W-1:0] UA_ACC_LAST  = 4'd5;
  localparam logic [PC_W-1:0] UA_CMD       = 4'd6;
  localparam logic [PC_W-1:0] UA_DUTY_MUL  = 4'd7;
  localparam logic [PC_W-1:0] UA_DUTY_DIV  = 4'd8;
  localparam logic [PC_W-1:0] UA_TICK_DONE = 4'd9;
  localparam logic [PC_W-1:0] UA_EVENT     = 4'd10;
  localparam logic [PC_W-1:0] UA_EVT_DONE  = 4'd11;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic            branch_event;
    logic [PC_W-1:0] target;
    logic            latch;
    logic            acc_clr;
    logic            diff_ld;
    mul_sel_t        mul_sel;
    logic            acc_add;
    logic            cmd_ld;
    logic            duty_prod_ld;
    logic            duty_ld;
    logic            enc_ld;
    logic            done;
  } ctrl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic                       mode;
    logic                       level_a;
    logic                       level_b;
    logic signed [DESIRE_W-1:0] desired_speed;
  } item_t;

endpackage
`default_nettype wire

// File: hw/rtl/encoder_pid_velocity_drive_unit.sv
// top level: stream ports, gain registers, input capture and output register
// an encoder event runs the dispatch, event and event-done steps of the microprogram,
// a control tick runs the steps from dispatch through tick-done
// throughput: one item at a time, a new item can be taken the cycle after the result
// enters the output register, which holds it while the next item is worked on
// reset: synchronous; count, speed, previous error, error sum and command clear,
// gains clear, encoder direction reads forward, no result is pending
`timescale 1ns / 1ps
`default_nettype none
module encoder_pid_velocity_drive_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [epvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output wire logic        s_tready,
  input  wire logic [23:0] s_tdata,   // level_a, level_b, desired_speed[15:0], zero pad
  input  wire logic        s_tuser,   // mode
  output wire logic        m_tvalid,
  input  wire logic        m_tready,
  // drive_forward, duty[9:0], measured_speed[14:0], encoder_forward, command[15:0], pad
  output wire logic [47:0] m_tdata
);
  import epvd_pkg::*;

  gains_t  gains;
  item_t   item;
  ctrl_t   ctrl;
  logic    ready;
  logic    stall;
  logic    in_acc;
  logic    out_valid;
  logic [47:0] out_data;

  logic              drive_forward;
  logic [DUTY_W-1:0] duty;
  logic [SPEED_W-1:0] measured_speed;
  logic              encoder_forward;
  logic [CMD_W-1:0]  command;

  assign in_acc = s_tvalid && ready;
  assign stall  = out_valid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P: gains.kp <= cfg_data;
        REG_GAIN_I: gains.ki <= cfg_data;
        REG_GAIN_D: gains.kd <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item.mode          <= s_tuser;
      item.level_a       <= s_tdata[0];
      item.level_b       <= s_tdata[1];
      item.desired_speed <= s_tdata[17:2];
    end
  end

  epvd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .is_event (!item.mode),
    .stall    (stall),
    .ready    (ready),
    .ctrl     (ctrl)
  );

  epvd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .gains           (gains),
    .item            (item),
    .drive_forward   (drive_forward),
    .duty            (duty),
    .measured_speed  (measured_speed),
    .encoder_forward (encoder_forward),
    .command         (command)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_data <= {5'd0, command, encoder_forward, measured_speed, duty, drive_forward};
    end
  end

  assign s_tready = ready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
`default_nettype wire

// File: hw/rtl/epvd_ucode_rom.sv
// control store: one control word per microprogram step
`timescale 1ns / 1ps
`default_nettype none
module epvd_ucode_rom (
  input  wire  logic [epvd_pkg::PC_W-1:0] addr,
  output epvd_pkg::ctrl_t                 word
);
  import epvd_pkg::*;

  always_comb begin
    word = '0;
    case (addr)
      UA_DISPATCH: begin
        word.branch_event = 1'b1;
        word.target       = UA_EVENT;
      end
      UA_LATCH: begin
        word.latch   = 1'b1;
        word.acc_clr = 1'b1;
      end
      UA_MUL_P: begin
        word.diff_ld = 1'b1;
        word.mul_sel = MUL_P;
      end
      UA_MUL_I: begin
        word.mul_sel = MUL_I;
        word.acc_add = 1'b1;
      end
      UA_MUL_D: begin
        word.mul_sel = MUL_D;
        word.acc_add = 1'b1;
      end
      UA_ACC_LAST:  word.acc_add      = 1'b1;
      UA_CMD:       word.cmd_ld       = 1'b1;
      UA_DUTY_MUL:  word.duty_prod_ld = 1'b1;
      UA_DUTY_DIV:  word.duty_ld      = 1'b1;
      UA_TICK_DONE: word.done         = 1'b1;
      UA_EVENT:     word.enc_ld       = 1'b1;
      UA_EVT_DONE:  word.done         = 1'b1;
      default:      word.done         = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/epvd_sequencer.sv
// step counter with conditional branch, issues gated control words
`timescale 1ns / 1ps
`default_nettype none
module epvd_sequencer (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  input  wire  logic is_event,
  input  wire  logic stall,
  output wire  logic ready,
  output epvd_pkg::ctrl_t ctrl
);
  import epvd_pkg::*;

  seq_state_t      state;
  seq_state_t      state_next;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_t           word;
  logic            active;

  epvd_ucode_rom u_rom (
    .addr (pc),
    .word (word)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN:  if (word.done && !stall) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // outputs and step counter
  always_comb begin
    active  = 1'b0;
    pc_next = pc;
    case (state)
      SEQ_IDLE: pc_next = UA_DISPATCH;
      SEQ_RUN: begin
        // a finished item holds on its last step until the output register frees
        active = !(word.done && stall);
        if (word.branch_event && is_event) begin
          pc_next = word.target;
        end else if (!word.done) begin
          pc_next = pc + 1'b1;
        end
      end
      default: pc_next = UA_DISPATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= UA_DISPATCH;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  assign ready = (state == SEQ_IDLE);
  assign ctrl  = active ? word : '0;

endmodule
`default_nettype wire

// File: hw/rtl/epvd_datapath.sv
// encoder count, pid arithmetic with one shared multiplier, and duty scaling
`timescale 1ns / 1ps
`default_nettype none
module epvd_datapath (
  input  wire  logic            clk,
  input  wire  logic            rst,
  input  epvd_pkg::ctrl_t       ctrl,
  input  epvd_pkg::gains_t      gains,
  input  epvd_pkg::item_t       item,
  output wire  logic            drive_forward,
  output wire  logic [epvd_pkg::DUTY_W-1:0]  duty,
  output wire  logic [epvd_pkg::SPEED_W-1:0] measured_speed,
  output wire  logic            encoder_forward,
  output wire  logic [epvd_pkg::CMD_W-1:0]   command
);
  import epvd_pkg::*;

  logic [COUNT_W-1:0]      edge_count;
  logic [SPEED_W-1:0]      speed_latch;
  logic [ERR_W-1:0]        prev_err;
  logic [ERR_W-1:0]        err;
  logic [DIFF_W-1:0]       diff;
  logic [SUM_W-1:0]        err_sum;
  logic [CMD_W-1:0]        cmd;
  logic                    enc_dir;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]        acc;
  logic [DPROD_W-1:0]      duty_prod;
  logic [DUTY_W-1:0]       duty_reg;

  logic                    fwd;
  logic [COUNT_W:0]        cnt_abs;
  logic [SPEED_W-1:0]      speed_next;
  logic [ERR_W-1:0]        err_next;
  logic [DIFF_W-1:0]       diff_next;
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic [QT_W-1:0]         q_trunc;
  logic [CMD_W-1:0]        cmd_next;
  logic [SUM_W:0]          sum_wide;
  logic [SUM_W-1:0]        sum_next;
  logic [CMD_W:0]          cmd_abs;
  logic [MAG_W-1:0]        mag;
  logic [DFULL_W-1:0]      duty_full;
  logic [DUTY_Q_W-1:0]     duty_q;
  logic [DUTY_W-1:0]       duty_next;

  always_comb begin
    fwd = (item.level_a == item.level_b);

    // magnitude of the count, 32768 saturates
    cnt_abs    = edge_count[COUNT_W-1] ? ((COUNT_W+1)'(0) - {1'b1, edge_count})
                                       : {1'b0, edge_count};
    speed_next = cnt_abs[SPEED_W] ? {SPEED_W{1'b1}} : cnt_abs[SPEED_W-1:0];
    err_next   = {item.desired_speed[DESIRE_W-1], item.desired_speed}
               - {{(ERR_W-SPEED_W){1'b0}}, speed_next};
    diff_next  = {err[ERR_W-1], err} - {prev_err[ERR_W-1], prev_err};

    case (ctrl.mul_sel)
      MUL_P: begin
        mul_a = gains.kp;
        mul_b = {{(MULB_W-ERR_W){err[ERR_W-1]}}, err};
      end
      MUL_I: begin
        mul_a = gains.ki;
        mul_b = {err_sum[SUM_W-1], err_sum};
      end
      MUL_D: begin
        mul_a = gains.kd;
        mul_b = {{(MULB_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = mul_a * mul_b;

    // divide by 256 rounding toward zero, then saturate to the command width
    q_trunc = acc[ACC_W-1:8]
            + {{(QT_W-1){1'b0}}, (acc[ACC_W-1] && (acc[7:0] != 8'd0))};
    if (q_trunc[QT_W-1:CMD_W-1] == {(QT_W-CMD_W+1){q_trunc[QT_W-1]}}) begin
      cmd_next = q_trunc[CMD_W-1:0];
    end else begin
      cmd_next = {q_trunc[QT_W-1], {(CMD_W-1){~q_trunc[QT_W-1]}}};
    end

    sum_wide = {err_sum[SUM_W-1], err_sum} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[SUM_W] == sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W-1:0];
    end else begin
      sum_next = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
    end

    cmd_abs = cmd[CMD_W-1] ? ((CMD_W+1)'(0) - {1'b1, cmd}) : {1'b0, cmd};
    mag     = (cmd_abs > (CMD_W+1)'(COMMAND_FULL_SCALE)) ? MAG_W'(COMMAND_FULL_SCALE)
                                                         : cmd_abs[MAG_W-1:0];

    // exact quotient by the reciprocal for every product below 2^DPROD_W
    duty_full = DFULL_W'(duty_prod) * DFULL_W'(DIV_MULT);
    duty_q    = DUTY_Q_W'(duty_full >> DIV_SHIFT);
    duty_next = (duty_q > DUTY_Q_W'(DUTY_MAX)) ? DUTY_MAX : duty_q[DUTY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count  <= '0;
      speed_latch <= '0;
      prev_err    <= '0;
      err_sum     <= '0;
      cmd         <= '0;
      enc_dir     <= 1'b1;
      duty_reg    <= '0;
    end else begin
      if (ctrl.enc_ld) begin
        enc_dir    <= fwd;
        edge_count <= edge_count + (fwd ? COUNT_W'(1) : {COUNT_W{1'b1}});
      end
      if (ctrl.latch) begin
        speed_latch <= speed_next;
        edge_count  <= '0;
      end
      if (ctrl.cmd_ld) begin
        cmd      <= cmd_next;
        prev_err <= err;
        err_sum  <= sum_next;
      end
      if (ctrl.duty_ld) duty_reg <= duty_next;
    end
  end

  // working registers of one tick
  always_ff @(posedge clk) begin
    if (ctrl.latch) err <= err_next;
    if (ctrl.diff_ld) diff <= diff_next;
    if (ctrl.mul_sel != MUL_NONE) prod <= prod_next;
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + {prod[PROD_W-1], prod};
    end
    if (ctrl.duty_prod_ld) duty_prod <= DPROD_W'(mag) * DPROD_W'(PWM_FULL_SCALE);
  end

  assign drive_forward   = ~cmd[CMD_W-1];
  assign duty            = duty_reg;
  assign measured_speed  = speed_latch;
  assign encoder_forward = enc_dir;
  assign command         = cmd;

endmodule
`default_nettype wire

// File: hw/rtl/epvd_checker.sv
// port-level checks for the drive unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module epvd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item at a time: the block is busy right after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while another is at work");

  // a new result only ends a run
  a_result_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without an item at work");

  // direction bit agrees with the command sign, duty is zero only for a zero command
  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == !m_tdata[42])
                 && ((m_tdata[10:1] == 10'd0) == (m_tdata[42:27] == 16'd0)))
    else $error("result fields disagree");

endmodule

bind encoder_pid_velocity_drive_unit epvd_checker u_epvd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
